>>> src/acf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Attitude complementary filter package
// Shared constants, configuration and command types, and the arctangent table.
// ----------------------------------------------------------------------------
package acf_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned CORDIC_ITERS =
      (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int unsigned ITER_W = 5;

  localparam logic signed [25:0] DEG180_Q16 = 26'sd11796480;
  localparam logic [16:0] BLEND_ONE = 17'd65536;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GYRO_X_OFFSET = 3'd0,
    REG_GYRO_Y_OFFSET = 3'd1,
    REG_GYRO_Z_OFFSET = 3'd2,
    REG_GYRO_SCALE    = 3'd3,
    REG_ACCEL_SCALE   = 3'd4,
    REG_BLEND_COEFF   = 3'd5,
    REG_TIME_STEP     = 3'd6
  } acf_reg_e;

  typedef struct packed {
    logic [15:0] gyro_x_offset;
    logic [15:0] gyro_y_offset;
    logic [15:0] gyro_z_offset;
    logic [23:0] gyro_scale_recip;
    logic [23:0] accel_scale_recip;
    logic [16:0] blend_coeff;
    logic [15:0] time_step;
  } acf_cfg_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_CINIT,
    DP_CSTEP,
    DP_CSAVE
  } acf_dp_op_e;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_RX,
    MUL_RY,
    MUL_RZ,
    MUL_VZ,
    MUL_RDT_P,
    MUL_RDT_R,
    MUL_A_LO,
    MUL_A_HI,
    MUL_B_P,
    MUL_B_R
  } acf_mul_e;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_RX,
    WB_RY,
    WB_RZ,
    WB_VZ,
    WB_GP_P,
    WB_GP_R,
    WB_ACC_SET,
    WB_ACC_ADD24,
    WB_ACC_ADD8,
    WB_EST_P,
    WB_EST_R
  } acf_wb_e;

  typedef struct packed {
    acf_dp_op_e        op;
    logic              axis;
    logic [ITER_W-1:0] iter;
    acf_mul_e          mul_sel;
    acf_wb_e           wb_sel;
  } acf_cmd_t;

  // Arctangent of 2^-i in degrees, Q16.
  function automatic logic [21:0] acf_atan(input logic [ITER_W-1:0] idx);
    logic [21:0] v;
    case (idx)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> src/acf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Attitude complementary filter controller
// Sequences the CORDIC passes and the multiply program for one sample set.
// ----------------------------------------------------------------------------
module acf_ctrl import acf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output acf_cmd_t  cmd_o,
  output logic      in_stall_o,
  input  wire logic out_free_i,
  output logic      out_load_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CINIT,
    ST_CRUN,
    ST_CSAVE,
    ST_SEQ,
    ST_DONE
  } state_e;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);
  localparam logic [4:0] SEQ_LAST = 5'd17;

  state_e            state_q;
  logic [ITER_W-1:0] iter_q;
  logic [4:0]        seq_q;
  logic              axis_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load_o = (state_q == ST_DONE) && out_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
      seq_q   <= '0;
      axis_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CINIT;
            axis_q  <= 1'b0;
          end
        end
        ST_CINIT: begin
          iter_q  <= '0;
          state_q <= ST_CRUN;
        end
        ST_CRUN: begin
          if (iter_q == ITER_LAST) begin
            state_q <= ST_CSAVE;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
        end
        ST_CSAVE: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= ST_CINIT;
          end else begin
            seq_q   <= '0;
            state_q <= ST_SEQ;
          end
        end
        ST_SEQ: begin
          if (seq_q == SEQ_LAST) begin
            state_q <= ST_DONE;
          end else begin
            seq_q <= seq_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Multiply program: a product issued in one step is written back in the next.
  always_comb begin
    cmd_o         = '0;
    cmd_o.op      = DP_NONE;
    cmd_o.axis    = axis_q;
    cmd_o.iter    = iter_q;
    cmd_o.mul_sel = MUL_NONE;
    cmd_o.wb_sel  = WB_NONE;
    case (state_q)
      ST_IDLE:  cmd_o.op = in_valid_i ? DP_LOAD : DP_NONE;
      ST_CINIT: cmd_o.op = DP_CINIT;
      ST_CRUN:  cmd_o.op = DP_CSTEP;
      ST_CSAVE: cmd_o.op = DP_CSAVE;
      ST_SEQ: begin
        case (seq_q)
          5'd0: cmd_o.mul_sel = MUL_RX;
          5'd1: begin
            cmd_o.mul_sel = MUL_RY;
            cmd_o.wb_sel  = WB_RX;
          end
          5'd2: begin
            cmd_o.mul_sel = MUL_RZ;
            cmd_o.wb_sel  = WB_RY;
          end
          5'd3: begin
            cmd_o.mul_sel = MUL_VZ;
            cmd_o.wb_sel  = WB_RZ;
          end
          5'd4: begin
            cmd_o.mul_sel = MUL_RDT_P;
            cmd_o.wb_sel  = WB_VZ;
          end
          5'd5: cmd_o.wb_sel = WB_GP_P;
          5'd6: cmd_o.mul_sel = MUL_A_LO;
          5'd7: begin
            cmd_o.mul_sel = MUL_A_HI;
            cmd_o.wb_sel  = WB_ACC_SET;
          end
          5'd8: begin
            cmd_o.mul_sel = MUL_B_P;
            cmd_o.wb_sel  = WB_ACC_ADD24;
          end
          5'd9:  cmd_o.wb_sel = WB_ACC_ADD8;
          5'd10: cmd_o.wb_sel = WB_EST_P;
          5'd11: cmd_o.mul_sel = MUL_RDT_R;
          5'd12: cmd_o.wb_sel = WB_GP_R;
          5'd13: cmd_o.mul_sel = MUL_A_LO;
          5'd14: begin
            cmd_o.mul_sel = MUL_A_HI;
            cmd_o.wb_sel  = WB_ACC_SET;
          end
          5'd15: begin
            cmd_o.mul_sel = MUL_B_R;
            cmd_o.wb_sel  = WB_ACC_ADD24;
          end
          5'd16: cmd_o.wb_sel = WB_ACC_ADD8;
          5'd17: cmd_o.wb_sel = WB_EST_R;
          default: cmd_o.wb_sel = WB_NONE;
        endcase
      end
      default: cmd_o.op = DP_NONE;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_CINIT && !axis_q))
    else $error("accepted transaction did not start the pitch CORDIC pass");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRUN) |-> (iter_q <= ITER_LAST))
    else $error("CORDIC iteration count out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |-> out_free_i)
    else $error("result loaded while output register is occupied");

  a_load_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load_o |=> (state_q == ST_IDLE))
    else $error("controller did not return to idle after delivering a result");

endmodule
`default_nettype wire

>>> src/acf_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Attitude complementary filter datapath
// Iterative vectoring CORDIC, one shared multiplier, accumulator and state.
// ----------------------------------------------------------------------------
module acf_dp import acf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire acf_cmd_t           cmd_i,
  input  wire acf_cfg_t           cfg_i,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  input  wire logic signed [15:0] gyro_x_i,
  input  wire logic signed [15:0] gyro_y_i,
  input  wire logic signed [15:0] gyro_z_i,
  output logic signed [17:0]      pitch_angle_out_o,
  output logic signed [17:0]      roll_angle_out_o,
  output logic signed [23:0]      pitch_rate_o,
  output logic signed [23:0]      roll_rate_o,
  output logic signed [23:0]      yaw_rate_o,
  output logic signed [15:0]      vertical_accel_o
);

  function automatic logic signed [23:0] sat24(input logic signed [51:0] v);
    logic signed [23:0] r;
    if (v > 52'sd8388607) r = 24'sh7FFFFF;
    else if (v < -52'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
    logic signed [15:0] r;
    if (v > 52'sd32767) r = 16'sh7FFF;
    else if (v < -52'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [59:0] v);
    logic signed [31:0] r;
    if (v > 60'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -60'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [17:0] sat18(input logic signed [32:0] v);
    logic signed [17:0] r;
    if (v > 33'sd131071) r = 18'sh1FFFF;
    else if (v < -33'sd131072) r = 18'sh20000;
    else r = v[17:0];
    return r;
  endfunction

  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [16:0] cx_q, cy_q, cz_q;
  logic signed [32:0] x_q, y_q;
  logic signed [25:0] z_q;
  logic               zero_q;
  logic signed [25:0] ang_p_q, ang_r_q;
  logic signed [23:0] rx_q, ry_q, rz_q;
  logic signed [15:0] vz_q;
  logic signed [51:0] prod_q;
  logic signed [40:0] gp_q;
  logic signed [59:0] acc_q;
  logic signed [31:0] est_p_q, est_r_q;

  // CORDIC set-up: a negative denominator turns the vector by 180 degrees.
  logic signed [16:0] num_s, den_s, num_t, den_t;
  logic signed [25:0] z_init;
  logic signed [32:0] dx, dy;
  logic signed [25:0] atan_s;

  always_comb begin
    num_s  = cmd_i.axis ? 17'(ax_q) : 17'(ay_q);
    den_s  = 17'(az_q);
    num_t  = num_s;
    den_t  = den_s;
    z_init = '0;
    if (den_s < 0) begin
      z_init = (num_s >= 0) ? DEG180_Q16 : -DEG180_Q16;
      num_t  = -num_s;
      den_t  = -den_s;
    end
    dx     = y_q >>> cmd_i.iter;
    dy     = x_q >>> cmd_i.iter;
    atan_s = 26'($signed({1'b0, acf_atan(cmd_i.iter)}));
  end

  // Shared multiplier operand selection.
  logic [16:0]        a_eff, b_eff;
  logic signed [25:0] mul_a, mul_b;

  always_comb begin
    a_eff = (cfg_i.blend_coeff > BLEND_ONE) ? BLEND_ONE : cfg_i.blend_coeff;
    b_eff = BLEND_ONE - a_eff;
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_RX: begin
        mul_a = 26'(cx_q);
        mul_b = $signed({2'b00, cfg_i.gyro_scale_recip});
      end
      MUL_RY: begin
        mul_a = 26'(cy_q);
        mul_b = $signed({2'b00, cfg_i.gyro_scale_recip});
      end
      MUL_RZ: begin
        mul_a = 26'(cz_q);
        mul_b = $signed({2'b00, cfg_i.gyro_scale_recip});
      end
      MUL_VZ: begin
        mul_a = 26'(az_q);
        mul_b = $signed({2'b00, cfg_i.accel_scale_recip});
      end
      MUL_RDT_P: begin
        mul_a = 26'(rx_q);
        mul_b = $signed({10'd0, cfg_i.time_step});
      end
      MUL_RDT_R: begin
        mul_a = 26'(ry_q);
        mul_b = $signed({10'd0, cfg_i.time_step});
      end
      MUL_A_LO: begin
        mul_a = $signed({9'd0, a_eff});
        mul_b = $signed({2'b00, gp_q[23:0]});
      end
      MUL_A_HI: begin
        mul_a = $signed({9'd0, a_eff});
        mul_b = 26'($signed(gp_q[40:24]));
      end
      MUL_B_P: begin
        mul_a = $signed({9'd0, b_eff});
        mul_b = ang_p_q;
      end
      MUL_B_R: begin
        mul_a = $signed({9'd0, b_eff});
        mul_b = ang_r_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Rounding: add one half, then floor.
  logic signed [51:0] rate_r, vz_r;
  logic signed [59:0] prod_x, est_r;
  logic signed [40:0] gp_p_d, gp_r_d;

  always_comb begin
    rate_r = (prod_q + 52'sd32768) >>> 16;
    vz_r   = (prod_q + 52'sd2048) >>> 12;
    prod_x = 60'(prod_q);
    est_r  = (acc_q + 60'sd8388608) >>> 24;
    gp_p_d = $signed({est_p_q[31], est_p_q, 8'd0}) + $signed(prod_q[40:0]);
    gp_r_d = $signed({est_r_q[31], est_r_q, 8'd0}) + $signed(prod_q[40:0]);
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        ax_q <= accel_x_i;
        ay_q <= accel_y_i;
        az_q <= accel_z_i;
        cx_q <= 17'(gyro_x_i) + 17'($signed(cfg_i.gyro_x_offset));
        cy_q <= 17'(gyro_y_i) + 17'($signed(cfg_i.gyro_y_offset));
        cz_q <= 17'(gyro_z_i) + 17'($signed(cfg_i.gyro_z_offset));
      end
      DP_CINIT: begin
        zero_q <= (num_s == 0) && (den_s == 0);
        x_q    <= 33'(den_t) <<< 14;
        y_q    <= 33'(num_t) <<< 14;
        z_q    <= z_init;
      end
      DP_CSTEP: begin
        if (!y_q[32]) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_s;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_s;
        end
      end
      DP_CSAVE: begin
        if (cmd_i.axis) ang_r_q <= zero_q ? '0 : z_q;
        else ang_p_q <= zero_q ? '0 : z_q;
      end
      default: ;
    endcase

    prod_q <= mul_a * mul_b;

    case (cmd_i.wb_sel)
      WB_RX:        rx_q <= sat24(rate_r);
      WB_RY:        ry_q <= sat24(rate_r);
      WB_RZ:        rz_q <= sat24(rate_r);
      WB_VZ:        vz_q <= sat16(vz_r);
      WB_GP_P:      gp_q <= gp_p_d;
      WB_GP_R:      gp_q <= gp_r_d;
      WB_ACC_SET:   acc_q <= prod_x;
      WB_ACC_ADD24: acc_q <= acc_q + (prod_x <<< 24);
      WB_ACC_ADD8:  acc_q <= acc_q + (prod_x <<< 8);
      default: ;
    endcase
  end

  // The filter state is the only datapath storage that reset clears.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_p_q <= '0;
      est_r_q <= '0;
    end else begin
      if (cmd_i.wb_sel == WB_EST_P) est_p_q <= sat32(est_r);
      if (cmd_i.wb_sel == WB_EST_R) est_r_q <= sat32(est_r);
    end
  end

  logic signed [32:0] p_rnd, r_rnd;
  assign p_rnd = ($signed({est_p_q[31], est_p_q}) + 33'sd128) >>> 8;
  assign r_rnd = ($signed({est_r_q[31], est_r_q}) + 33'sd128) >>> 8;

  assign pitch_angle_out_o = sat18(p_rnd);
  assign roll_angle_out_o  = sat18(r_rnd);
  assign pitch_rate_o      = rx_q;
  assign roll_rate_o       = ry_q;
  assign yaw_rate_o        = rz_q;
  assign vertical_accel_o  = vz_q;

endmodule
`default_nettype wire

>>> src/attitude_complementary_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Attitude complementary filter core
// Tilt from accelerometer by CORDIC, gyro rates, complementary pitch/roll blend.
// ----------------------------------------------------------------------------
// Sample sets are taken one at a time: in_stall_o stays high until the result of
// the last set has been loaded into the output register, since the single CORDIC
// unit runs both tilt angles and there is one shared multiplier.
// Reset: asynchronous; configuration returns to its defaults and the pitch and
// roll estimates clear to zero.
module attitude_complementary_filter_core import acf_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic signed [15:0]    accel_x_i,
  input  wire logic signed [15:0]    accel_y_i,
  input  wire logic signed [15:0]    accel_z_i,
  input  wire logic signed [15:0]    gyro_x_i,
  input  wire logic signed [15:0]    gyro_y_i,
  input  wire logic signed [15:0]    gyro_z_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [17:0]         pitch_angle_out_o,
  output logic signed [17:0]         roll_angle_out_o,
  output logic signed [23:0]         pitch_rate_o,
  output logic signed [23:0]         roll_rate_o,
  output logic signed [23:0]         yaw_rate_o,
  output logic signed [15:0]         vertical_accel_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  acf_cfg_t cfg_q;
  acf_cmd_t cmd;
  logic     out_load;
  logic     out_free;
  logic     out_valid_q;

  logic signed [17:0] pitch_d, roll_d;
  logic signed [23:0] prate_d, rrate_d, yrate_d;
  logic signed [15:0] vacc_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gyro_x_offset     <= 16'd433;
      cfg_q.gyro_y_offset     <= 16'hFFC3;
      cfg_q.gyro_z_offset     <= 16'hFF38;
      cfg_q.gyro_scale_recip  <= 24'd128070;
      cfg_q.accel_scale_recip <= 24'd1024;
      cfg_q.blend_coeff       <= 17'd60293;
      cfg_q.time_step         <= 16'd1311;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GYRO_X_OFFSET: cfg_q.gyro_x_offset     <= cfg_data_i[15:0];
        REG_GYRO_Y_OFFSET: cfg_q.gyro_y_offset     <= cfg_data_i[15:0];
        REG_GYRO_Z_OFFSET: cfg_q.gyro_z_offset     <= cfg_data_i[15:0];
        REG_GYRO_SCALE:    cfg_q.gyro_scale_recip  <= cfg_data_i;
        REG_ACCEL_SCALE:   cfg_q.accel_scale_recip <= cfg_data_i;
        REG_BLEND_COEFF:   cfg_q.blend_coeff       <= cfg_data_i[16:0];
        REG_TIME_STEP:     cfg_q.time_step         <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  acf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .out_load_o (out_load)
  );

  acf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_i             (cfg_q),
    .accel_x_i         (accel_x_i),
    .accel_y_i         (accel_y_i),
    .accel_z_i         (accel_z_i),
    .gyro_x_i          (gyro_x_i),
    .gyro_y_i          (gyro_y_i),
    .gyro_z_i          (gyro_z_i),
    .pitch_angle_out_o (pitch_d),
    .roll_angle_out_o  (roll_d),
    .pitch_rate_o      (prate_d),
    .roll_rate_o       (rrate_d),
    .yaw_rate_o        (yrate_d),
    .vertical_accel_o  (vacc_d)
  );

  // The output register frees up in the same cycle its transaction completes.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pitch_angle_out_o <= pitch_d;
      roll_angle_out_o  <= roll_d;
      pitch_rate_o      <= prate_d;
      roll_rate_o       <= rrate_d;
      yaw_rate_o        <= yrate_d;
      vertical_accel_o  <= vacc_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Attitude complementary filter core testbench
// Feeds IMU sample sets through random gaps, stalls the result side at random,
// and checks every result against a bit-exact tilt, rate and blend predictor
// across several register settings.
// ----------------------------------------------------------------------------
module tb;
  import acf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [15:0] ax, ay, az, gx, gy, gz;
  } imu_sample_t;

  typedef struct {
    logic signed [17:0] pitch, roll;
    logic signed [23:0] prate, rrate, yrate;
    logic signed [15:0] vaccel;
  } attitude_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic signed [15:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [15:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;

  logic in_stall, out_valid, cfg_ready;
  logic signed [17:0] pitch_o, roll_o;
  logic signed [23:0] prate_o, rrate_o, yrate_o;
  logic signed [15:0] vaccel_o;

  imu_sample_t sample_queue[$];
  attitude_t pending_results[$];
  int unsigned error_count = 0;
  bit burst_mode = 1'b0;

  // Predictor copy of the registers and the filter state.
  logic signed [15:0] off_x, off_y, off_z;
  logic [23:0] gyro_scale, accel_scale;
  logic [16:0] blend_a;
  logic [15:0] dt_q16;
  longint pitch_est, roll_est;

  longint atan_deg[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  always #1 clk = ~clk;

  attitude_complementary_filter_core u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .accel_x_i(accel_x), .accel_y_i(accel_y), .accel_z_i(accel_z),
    .gyro_x_i(gyro_x), .gyro_y_i(gyro_y), .gyro_z_i(gyro_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pitch_angle_out_o(pitch_o), .roll_angle_out_o(roll_o),
    .pitch_rate_o(prate_o), .roll_rate_o(rrate_o), .yaw_rate_o(yrate_o),
    .vertical_accel_o(vaccel_o),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  function automatic longint round_q(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    return (v > hi) ? hi : ((v < -hi - 1) ? -hi - 1 : v);
  endfunction

  // Vectoring CORDIC: atan2(num, den) in Q16 degrees.
  function automatic longint tilt_angle(longint num, longint den);
    longint x, y, z, dx, dy;
    x = den;
    y = num;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 11796480 : -11796480;
      x = -x;
      y = -y;
    end
    x = x * 16384;
    y = y * 16384;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_deg[i];
      end else begin
        x -= dx; y += dy; z -= atan_deg[i];
      end
    end
    return z;
  endfunction

  function automatic longint corrected_rate(logic signed [15:0] raw, logic signed [15:0] off);
    longint c;
    c = longint'(raw) + longint'(off);
    return clamp(round_q(c * longint'({40'd0, gyro_scale}), 16), 24);
  endfunction

  function automatic longint blended(longint est, longint rate, longint ang, longint a);
    longint gyro_path, acc;
    gyro_path = est * 256 + rate * longint'({48'd0, dt_q16});
    acc = a * gyro_path + (65536 - a) * (ang * 256);
    return clamp(round_q(acc, 24), 32);
  endfunction

  function automatic void predict_attitude(imu_sample_t s);
    attitude_t r;
    longint rx, ry, a;
    rx = corrected_rate(s.gx, off_x);
    ry = corrected_rate(s.gy, off_y);
    a = (blend_a > BLEND_ONE) ? 65536 : longint'({47'd0, blend_a});
    pitch_est = blended(pitch_est, rx, tilt_angle(s.ay, s.az), a);
    roll_est = blended(roll_est, ry, tilt_angle(s.ax, s.az), a);
    r.pitch = 18'(clamp(round_q(pitch_est, 8), 18));
    r.roll = 18'(clamp(round_q(roll_est, 8), 18));
    r.prate = 24'(rx);
    r.rrate = 24'(ry);
    r.yrate = 24'(corrected_rate(s.gz, off_z));
    r.vaccel = 16'(clamp(round_q(longint'(s.az) * longint'({40'd0, accel_scale}), 12), 16));
    pending_results.push_back(r);
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Sender: one queued sample set per transaction, random gaps between them.
  always @(posedge clk) begin
    int unsigned gap;
    bit taken;
    if (rst_n) begin
      taken = in_valid && !in_stall;
      if (taken) begin
        predict_attitude('{accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z});
        if ($urandom_range(0, 30) == 0) burst_mode = ~burst_mode;
        gap = burst_mode ? 0 : $urandom_range(0, 13);
      end
      if (taken || !in_valid) begin
        if (gap != 0 || sample_queue.size() == 0) begin
          if (gap != 0) gap--;
          in_valid <= 1'b0;
        end else begin
          imu_sample_t s;
          s = sample_queue.pop_front();
          accel_x <= s.ax; accel_y <= s.ay; accel_z <= s.az;
          gyro_x <= s.gx; gyro_y <= s.gy; gyro_z <= s.gz;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Receiver: random stalls, and every result checked against the oldest prediction.
  always @(posedge clk) begin
    int unsigned hold;
    attitude_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("result transaction with no prediction waiting");
          error_count++;
        end else begin
          e = pending_results.pop_front();
          if (pitch_o !== e.pitch) report("pitch_angle_out", pitch_o, e.pitch);
          if (roll_o !== e.roll) report("roll_angle_out", roll_o, e.roll);
          if (prate_o !== e.prate) report("pitch_rate", prate_o, e.prate);
          if (rrate_o !== e.rrate) report("roll_rate", rrate_o, e.rrate);
          if (yrate_o !== e.yrate) report("yaw_rate", yrate_o, e.yrate);
          if (vaccel_o !== e.vaccel) report("vertical_accel", vaccel_o, e.vaccel);
        end
        hold = burst_mode ? 0 : $urandom_range(0, 13);
      end
      if (hold != 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    int unsigned quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GYRO_X_OFFSET: off_x = d[15:0];
      REG_GYRO_Y_OFFSET: off_y = d[15:0];
      REG_GYRO_Z_OFFSET: off_z = d[15:0];
      REG_GYRO_SCALE:    gyro_scale = d;
      REG_ACCEL_SCALE:   accel_scale = d;
      REG_BLEND_COEFF:   blend_a = d[16:0];
      REG_TIME_STEP:     dt_q16 = d[15:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add(int ax, int ay, int az, int gx, int gy, int gz);
    sample_queue.push_back('{16'(ax), 16'(ay), 16'(az), 16'(gx), 16'(gy), 16'(gz)});
  endtask

  // Mostly a board near level with small rates, the rest full-range noise.
  task automatic add_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 2) != 0)
        add($signed($urandom_range(0, 8000)) - 4000, $signed($urandom_range(0, 8000)) - 4000,
            $urandom_range(0, 1) ? 16384 - $urandom_range(0, 3000) : -16384,
            $signed($urandom_range(0, 2000)) - 1000, $signed($urandom_range(0, 2000)) - 1000,
            $signed($urandom_range(0, 2000)) - 1000);
      else
        add($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic random_config;
    write_reg(REG_GYRO_X_OFFSET, $urandom);
    write_reg(REG_GYRO_Y_OFFSET, $urandom);
    write_reg(REG_GYRO_Z_OFFSET, $urandom);
    write_reg(REG_GYRO_SCALE, $urandom_range(0, 1) ? $urandom_range(0, 400000) : $urandom);
    write_reg(REG_ACCEL_SCALE, $urandom_range(0, 1) ? $urandom_range(0, 8192) : $urandom);
    write_reg(REG_BLEND_COEFF, $urandom_range(0, 131071));
    write_reg(REG_TIME_STEP, $urandom);
  endtask

  initial begin
    off_x = 16'sd433;
    off_y = -16'sd61;
    off_z = -16'sd200;
    gyro_scale = 24'd128070;
    accel_scale = 24'd1024;
    blend_a = 17'd60293;
    dt_q16 = 16'd1311;
    pitch_est = 0;
    roll_est = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings.
    add(0, 0, 0, 0, 0, 0);
    add(0, 0, 16384, 0, 0, 0);
    add(0, 0, -16384, 0, 0, 0);
    add(1000, -1000, -8000, 100, -100, 50);
    add(32767, 32767, 32767, 32767, 32767, 32767);
    add(-32768, -32768, -32768, -32768, -32768, -32768);
    add(32767, -32768, 0, -32768, 32767, 0);
    add(-32768, 32767, 0, 0, 0, 0);
    add(16384, 0, 1, -433, 61, 200);
    add(0, 5, -1, 1, -1, 1);
    add(-1, -1, -1, -1, -1, -1);
    drain();

    // Extremes: largest scales, offsets and step, blend above one.
    write_reg(REG_GYRO_X_OFFSET, 24'h007fff);
    write_reg(REG_GYRO_Y_OFFSET, 24'h008000);
    write_reg(REG_GYRO_Z_OFFSET, 24'hff7fff);
    write_reg(REG_GYRO_SCALE, 24'hffffff);
    write_reg(REG_ACCEL_SCALE, 24'hffffff);
    write_reg(REG_BLEND_COEFF, 24'h01ffff);
    write_reg(REG_TIME_STEP, 24'h00ffff);
    write_reg(REG_UNUSED, 24'h123456);
    add(0, 0, 32767, 32767, -32768, 32767);
    add(0, 0, 32767, 32767, -32768, 32767);
    add(-32768, 32767, -32768, -32768, 32767, -32768);
    add(0, 0, 0, -32768, -32768, -32768);
    add_random(30);
    drain();

    // Other extremes: zero everything, then blend exactly one.
    write_reg(REG_GYRO_X_OFFSET, 0);
    write_reg(REG_GYRO_Y_OFFSET, 0);
    write_reg(REG_GYRO_Z_OFFSET, 0);
    write_reg(REG_GYRO_SCALE, 0);
    write_reg(REG_ACCEL_SCALE, 0);
    write_reg(REG_BLEND_COEFF, 0);
    write_reg(REG_TIME_STEP, 0);
    add(100, 200, 300, 400, 500, 600);
    add_random(30);
    drain();
    write_reg(REG_BLEND_COEFF, 24'h010000);
    write_reg(REG_GYRO_SCALE, 24'd128070);
    write_reg(REG_TIME_STEP, 24'd1311);
    add_random(30);
    drain();

    repeat (6) begin
      random_config();
      if ($urandom_range(0, 1)) write_reg(REG_UNUSED, $urandom);
      add_random(50);
      drain();
    end

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> sim.f
src/acf_pkg.sv
src/acf_ctrl.sv
src/acf_dp.sv
src/attitude_complementary_filter_core.sv
bench/tb.sv
